// ===== rtl/core/sag_pkg.sv =====
// Shared types and constants for the sag limiter with moving-sum envelope.
// Holds controller state, command/status structs and fixed field widths.
// No dependencies.
`default_nettype none

package sag_pkg;

    // Default geometry, handed down from the top level
    localparam int DEF_RING_DEPTH  = 16385;
    localparam int DEF_SAMPLE_BITS = 24;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WET_MIX       = 1'd1;

    // Register widths
    localparam int WIN_W = 15;
    localparam int MIX_W = 16;
    localparam int MIX_FRAC = 14;
    localparam logic signed [MIX_W-1:0] MIX_POS = 16'sd16384;
    localparam logic signed [MIX_W-1:0] MIX_NEG = -16'sd16384;

    // Square root of the window, 16 fractional bits: sqrt(W << 32)
    localparam int ROOT_SHIFT = 32;
    localparam int ROOT_W     = 24;
    localparam int ROOT_STEPS = ROOT_W;

    // Gain: unsigned, 23 fractional bits; divisor carries the sum << 16
    localparam int GAIN_BITS = 23;
    localparam int GAIN_W    = GAIN_BITS + 1;
    localparam int DEN_SHIFT = 16;

    localparam int STEP_W = 5;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WRITE,
        ST_READ,
        ST_SUM,
        ST_CHECK,
        ST_ROOT,
        ST_DIVLOAD,
        ST_DIV,
        ST_MUL,
        ST_SAG,
        ST_MIX,
        ST_OUT
    } sag_state_t;

    typedef struct packed {
        logic clear_wr;
        logic capture;
        logic ring_wr;
        logic ring_rd;
        logic sum_upd;
        logic check;
        logic root_load;
        logic root_step;
        logic div_load;
        logic div_step;
        logic mul;
        logic sag;
        logic mix;
        logic out_load;
    } sag_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic sum_zero;
        logic root_ok;
        logic gain_sat;
    } sag_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/sag_limiter_moving_sum.sv =====
// Top level of the sag limiter: configuration registers, controller, datapath.
// Depends on sag_pkg, sag_ctrl, sag_dp (which holds the sag_ram ring).
//
//  channel   | handshake              | payload
//  ----------+------------------------+-------------------------------------
//  input     | s_valid / s_ready      | s_sample_in  (signed Q1.23)
//  result    | m_valid / m_ready      | m_sample_out (signed Q1.23, saturated)
//  config    | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
//  Each item passes write, read, sum and check, then the 23-step restoring
//  divider for the gain, then multiply, sag, mix and output. After a change
//  of window_length the first item with a non-empty sum also runs the
//  bit-pair square root; an empty sum skips root and divider, a unity gain
//  skips the divider. After reset a clearing pass zeroes the ring with
//  s_ready low; configuration writes are taken throughout (cfg_ready is high).
//  The result sits in an output register; while it waits for m_ready the next
//  item is accepted and worked on, and then holds until the register frees.
`default_nettype none

module sag_limiter_moving_sum import sag_pkg::*; #(
    parameter int RING_DEPTH  = DEF_RING_DEPTH,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // input item
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic signed [SAMPLE_BITS-1:0] s_sample_in,
    // result item
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic signed      [SAMPLE_BITS-1:0] m_sample_out,
    // configuration writes
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic        [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic        [CFG_DATA_W-1:0]  cfg_data
);

    localparam int CLAMP_W = (($clog2(RING_DEPTH) > WIN_W) ? $clog2(RING_DEPTH) : WIN_W) + 1;
    localparam logic [CLAMP_W-1:0] TOP_IDX = CLAMP_W'(RING_DEPTH - 1);

    logic        [WIN_W-1:0] window_length_reg;
    logic signed [MIX_W-1:0] wet_mix_reg;
    logic        [WIN_W-1:0] win_eff;
    logic signed [MIX_W-1:0] mix_eff;

    sag_cmd_t  cmd;
    sag_stat_t stat;

    // Writes land whenever offered; software must write only while the block is idle (not enforced here).
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_length_reg <= WIN_W'(1);
            wet_mix_reg       <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_WINDOW_LENGTH: window_length_reg <= cfg_data[WIN_W-1:0];
                CFG_WET_MIX:       wet_mix_reg       <= $signed(cfg_data[MIX_W-1:0]);
            endcase
        end
    end

    // Hold the window inside [1, top ring index] and the mix inside [-1, +1].
    always_comb begin
        priority if (window_length_reg == '0) begin
            win_eff = WIN_W'(1);
        end else if (CLAMP_W'(window_length_reg) > TOP_IDX) begin
            win_eff = TOP_IDX[WIN_W-1:0];
        end else begin
            win_eff = window_length_reg;
        end

        priority if (wet_mix_reg > MIX_POS) begin
            mix_eff = MIX_POS;
        end else if (wet_mix_reg < MIX_NEG) begin
            mix_eff = MIX_NEG;
        end else begin
            mix_eff = wet_mix_reg;
        end
    end

    // Sequencer: one item at a time through ring update, root, divide, mix.
    sag_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Arithmetic and the magnitude ring.
    sag_dp #(
        .RING_DEPTH  (RING_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .win_eff    (win_eff),
        .mix_eff    (mix_eff),
        .sample_in  (s_sample_in),
        .sample_out (m_sample_out)
    );

    // No item may be taken while the clearing pass still owns the ring.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !cmd.clear_wr)
        else $error("input ready during ring clear");

    // An accepted item is written into the ring on the following cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> cmd.ring_wr)
        else $error("accepted item not written to ring");

    // A new result never overwrites one still waiting downstream.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid || m_ready))
        else $error("result loaded over a pending result");

    // A result appears only after the controller loads one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(cmd.out_load))
        else $error("result valid without a load");

endmodule

`default_nettype wire

// ===== rtl/core/sag_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module sag_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/sag_dp.sv =====
// Datapath: magnitude ring, windowed sum, root and gain iterations, mixer.
// Depends on sag_pkg and sag_ram; driven by commands from sag_ctrl.
`default_nettype none

module sag_dp import sag_pkg::*; #(
    parameter int RING_DEPTH  = DEF_RING_DEPTH,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire sag_cmd_t                      cmd,
    output sag_stat_t                          stat,
    input  wire logic        [WIN_W-1:0]       win_eff,
    input  wire logic signed [MIX_W-1:0]       mix_eff,
    input  wire logic signed [SAMPLE_BITS-1:0] sample_in,
    output logic signed      [SAMPLE_BITS-1:0] sample_out
);

    localparam int ADDR_W = $clog2(RING_DEPTH);
    localparam int FRAC   = SAMPLE_BITS - 1;
    localparam int MAG_W  = SAMPLE_BITS - 1;
    localparam int SUM_W  = WIN_W + SAMPLE_BITS - 1;
    localparam int AH_W   = ((ADDR_W > WIN_W) ? ADDR_W : WIN_W) + 1;
    // common power of two dropped from numerator and divisor
    localparam int SHR    = (FRAC < DEN_SHIFT) ? FRAC : DEN_SHIFT;
    localparam int NUM_W  = ROOT_W + FRAC - SHR;
    localparam int DEN_W  = SUM_W + DEN_SHIFT - SHR;
    localparam int CMP_W  = (NUM_W > DEN_W) ? NUM_W : DEN_W;
    localparam int B_W    = (GAIN_W > MAG_W) ? GAIN_W : MAG_W;
    localparam int PROD_W = SAMPLE_BITS + B_W + 1;
    localparam int P_W    = SAMPLE_BITS + MIX_W + 1;
    localparam int ACC_W  = P_W + 1;

    localparam logic [ADDR_W-1:0] TOP_ADDR = ADDR_W'(RING_DEPTH - 1);
    localparam logic [AH_W-1:0]   TOP_AH   = AH_W'(RING_DEPTH - 1);
    localparam logic signed [ACC_W-1:0] Y_MAX = ACC_W'((64'sd1 <<< FRAC) - 64'sd1);
    localparam logic signed [ACC_W-1:0] Y_MIN = ACC_W'(-(64'sd1 <<< FRAC));

    // Ring and sum state
    logic [ADDR_W-1:0] ptr_reg;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic              root_valid_reg;

    // Item payload
    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic [MAG_W-1:0]              mag_reg;
    logic [ADDR_W-1:0]             ahead_reg;
    logic                          square_reg;

    // Root and divider iterations
    logic [2*ROOT_W-1:0] rad_reg;
    logic [ROOT_W-1:0]   rrem_reg;
    logic [ROOT_W-1:0]   root_reg;
    logic [WIN_W-1:0]    root_win_reg;
    logic [DEN_W-1:0]    rem_reg;
    logic [GAIN_W-1:0]   gain_reg;

    // Products
    logic signed [PROD_W-1:0]      prod_reg;
    logic signed [SAMPLE_BITS:0]   diff_reg;
    logic signed [P_W-1:0]         p1_reg;
    logic signed [P_W-1:0]         p2_reg;
    logic signed [SAMPLE_BITS-1:0] out_reg;

    // Ring memory
    logic              ram_wr_en;
    logic [ADDR_W-1:0] ram_wr_addr;
    logic [MAG_W-1:0]  ram_wr_data;
    logic [MAG_W-1:0]  ram_rd_data;

    // Combinational helpers
    logic [SAMPLE_BITS-1:0] abs_w;
    logic [MAG_W-1:0]       mag_w;
    logic [AH_W-1:0]        ahead_sum;
    logic [AH_W-1:0]        ahead_w;
    logic [SUM_W+1:0]       sum_ext;
    logic [SUM_W-1:0]       limit_w;
    logic [SUM_W-1:0]       sum_w;
    logic [ROOT_W+1:0]      rtry_w;
    logic [ROOT_W+1:0]      rtrial_w;
    logic [CMP_W-1:0]       num_c;
    logic [CMP_W-1:0]       den_c;
    logic [DEN_W:0]         two_r;
    logic [DEN_W:0]         den_x;
    logic [B_W-1:0]         b_w;
    logic signed [PROD_W-1:0]      shifted_w;
    logic signed [SAMPLE_BITS-1:0] sag_w;
    logic [MIX_W-1:0]       dry_w;
    logic signed [ACC_W-1:0] acc_w;
    logic signed [ACC_W-1:0] y_w;
    logic signed [SAMPLE_BITS-1:0] y_sat;

    sag_ram #(
        .WIDTH (MAG_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (cmd.ring_rd),
        .rd_addr (ahead_reg),
        .rd_data (ram_rd_data)
    );

    always_comb begin
        // magnitude, the most negative sample saturating to full scale minus one
        abs_w = sample_in[SAMPLE_BITS-1] ? (SAMPLE_BITS'(0) - SAMPLE_BITS'(sample_in))
                                         : SAMPLE_BITS'(sample_in);
        mag_w = abs_w[SAMPLE_BITS-1] ? {MAG_W{1'b1}} : abs_w[MAG_W-1:0];

        // entry one window ahead, wrapping by the top index
        ahead_sum = AH_W'(ptr_reg) + AH_W'(win_eff);
        ahead_w   = (ahead_sum > TOP_AH) ? (ahead_sum - TOP_AH) : ahead_sum;

        // running sum clamped to [0, W * full scale]
        sum_ext = (SUM_W+2)'(sum_reg) + (SUM_W+2)'(mag_reg) - (SUM_W+2)'(ram_rd_data);
        limit_w = SUM_W'(win_eff) << FRAC;
        if (sum_ext[SUM_W+1]) begin
            sum_w = '0;
        end else if (sum_ext[SUM_W:0] > {1'b0, limit_w}) begin
            sum_w = limit_w;
        end else begin
            sum_w = sum_ext[SUM_W-1:0];
        end

        // one digit of the square root
        rtry_w   = {rrem_reg, rad_reg[2*ROOT_W-1 -: 2]};
        rtrial_w = {root_reg, 2'b01};

        // gain division operands
        num_c = CMP_W'(root_reg) << (FRAC - SHR);
        den_c = CMP_W'(sum_reg) << (DEN_SHIFT - SHR);
        two_r = {rem_reg, 1'b0};
        den_x = {1'b0, den_c[DEN_W-1:0]};

        // multiplier operand: gain, or the positive sample when the sum is empty
        if (square_reg) begin
            b_w = x_reg[SAMPLE_BITS-1] ? '0 : B_W'(x_reg[MAG_W-1:0]);
        end else begin
            b_w = B_W'(gain_reg);
        end
        shifted_w = square_reg ? (prod_reg >>> FRAC) : (prod_reg >>> GAIN_BITS);
        sag_w     = shifted_w[SAMPLE_BITS-1:0];

        dry_w = mix_eff[MIX_W-1] ? (MIX_W'(MIX_POS) + MIX_W'(mix_eff)) : MIX_W'(MIX_POS);

        acc_w = ACC_W'(p1_reg) - ACC_W'(p2_reg);
        y_w   = acc_w >>> MIX_FRAC;
        if (y_w > Y_MAX) begin
            y_sat = Y_MAX[SAMPLE_BITS-1:0];
        end else if (y_w < Y_MIN) begin
            y_sat = Y_MIN[SAMPLE_BITS-1:0];
        end else begin
            y_sat = y_w[SAMPLE_BITS-1:0];
        end

        ram_wr_en   = cmd.clear_wr | cmd.ring_wr;
        ram_wr_addr = cmd.clear_wr ? clr_addr_reg : ptr_reg;
        ram_wr_data = cmd.clear_wr ? '0 : mag_reg;
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg        <= '0;
            clr_addr_reg   <= '0;
            sum_reg        <= '0;
            root_valid_reg <= 1'b0;
            square_reg     <= 1'b0;
        end else begin
            if (cmd.clear_wr && (clr_addr_reg != TOP_ADDR)) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (cmd.ring_wr) begin
                ptr_reg <= (ptr_reg == '0) ? TOP_ADDR : (ptr_reg - 1'b1);
            end
            if (cmd.sum_upd) begin
                sum_reg <= sum_w;
            end
            if (cmd.check) begin
                square_reg <= (sum_reg == '0);
            end
            if (cmd.root_load) begin
                root_valid_reg <= 1'b0;
            end else if (cmd.div_load) begin
                root_valid_reg <= 1'b1;
            end
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            x_reg     <= sample_in;
            mag_reg   <= mag_w;
            ahead_reg <= ahead_w[ADDR_W-1:0];
        end
        if (cmd.root_load) begin
            rad_reg      <= (2*ROOT_W)'({win_eff, {ROOT_SHIFT{1'b0}}});
            rrem_reg     <= '0;
            root_reg     <= '0;
            root_win_reg <= win_eff;
        end else if (cmd.root_step) begin
            rad_reg <= rad_reg << 2;
            if (rtry_w >= rtrial_w) begin
                rrem_reg <= ROOT_W'(rtry_w - rtrial_w);
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end else begin
                rrem_reg <= rtry_w[ROOT_W-1:0];
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
        if (cmd.div_load) begin
            rem_reg  <= num_c[DEN_W-1:0];
            gain_reg <= (num_c >= den_c) ? (GAIN_W'(1) << GAIN_BITS) : '0;
        end else if (cmd.div_step) begin
            if (two_r >= den_x) begin
                rem_reg  <= DEN_W'(two_r - den_x);
                gain_reg <= {gain_reg[GAIN_W-2:0], 1'b1};
            end else begin
                rem_reg  <= two_r[DEN_W-1:0];
                gain_reg <= {gain_reg[GAIN_W-2:0], 1'b0};
            end
        end
        if (cmd.mul) begin
            prod_reg <= PROD_W'(x_reg) * PROD_W'($signed({1'b0, b_w}));
        end
        if (cmd.sag) begin
            diff_reg <= $signed({x_reg[SAMPLE_BITS-1], x_reg})
                      - $signed({sag_w[SAMPLE_BITS-1], sag_w});
        end
        if (cmd.mix) begin
            p1_reg <= P_W'(x_reg) * P_W'($signed({1'b0, dry_w}));
            p2_reg <= P_W'(diff_reg) * P_W'(mix_eff);
        end
        if (cmd.out_load) begin
            out_reg <= y_sat;
        end
    end

    assign stat.clear_last = (clr_addr_reg == TOP_ADDR);
    assign stat.sum_zero   = (sum_reg == '0);
    assign stat.root_ok    = root_valid_reg && (root_win_reg == win_eff);
    assign stat.gain_sat   = (num_c >= den_c);
    assign sample_out      = out_reg;

endmodule

`default_nettype wire

// ===== rtl/core/sag_ctrl.sv =====
// Controller: sequences clear pass, ring update, root, division and mixing.
// Depends on sag_pkg; talks to sag_dp through command and status structs.
`default_nettype none

module sag_ctrl import sag_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    output logic           m_valid,
    input  wire logic      m_ready,
    input  wire sag_stat_t stat,
    output sag_cmd_t       cmd
);

    sag_state_t        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              m_valid_reg, m_valid_next;
    logic              step_last;
    logic              out_free;

    assign step_last = (step_reg == '0);
    assign out_free  = !m_valid_reg || m_ready;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:   if (stat.clear_last) state_next = ST_IDLE;
            ST_IDLE:    if (s_valid) state_next = ST_WRITE;
            ST_WRITE:   state_next = ST_READ;
            ST_READ:    state_next = ST_SUM;
            ST_SUM:     state_next = ST_CHECK;
            ST_CHECK: begin
                priority if (stat.sum_zero) state_next = ST_MUL;
                else if (!stat.root_ok)     state_next = ST_ROOT;
                else                        state_next = ST_DIVLOAD;
            end
            ST_ROOT:    if (step_last) state_next = ST_DIVLOAD;
            ST_DIVLOAD: state_next = stat.gain_sat ? ST_MUL : ST_DIV;
            ST_DIV:     if (step_last) state_next = ST_MUL;
            ST_MUL:     state_next = ST_SAG;
            ST_SAG:     state_next = ST_MIX;
            ST_MIX:     state_next = ST_OUT;
            ST_OUT:     if (out_free) state_next = ST_IDLE;
            default:    state_next = ST_CLEAR;
        endcase
    end

    // Commands
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_CLEAR:   cmd.clear_wr = 1'b1;
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            ST_WRITE:   cmd.ring_wr = 1'b1;
            ST_READ:    cmd.ring_rd = 1'b1;
            ST_SUM:     cmd.sum_upd = 1'b1;
            ST_CHECK: begin
                cmd.check     = 1'b1;
                cmd.root_load = !stat.sum_zero && !stat.root_ok;
            end
            ST_ROOT:    cmd.root_step = 1'b1;
            ST_DIVLOAD: cmd.div_load = 1'b1;
            ST_DIV:     cmd.div_step = 1'b1;
            ST_MUL:     cmd.mul = 1'b1;
            ST_SAG:     cmd.sag = 1'b1;
            ST_MIX:     cmd.mix = 1'b1;
            ST_OUT:     cmd.out_load = out_free;
            default:    cmd = '0;
        endcase
    end

    // Iteration counter and output valid
    always_comb begin
        priority if (cmd.root_load) begin
            step_next = STEP_W'(ROOT_STEPS - 1);
        end else if (cmd.div_load) begin
            step_next = STEP_W'(GAIN_BITS - 1);
        end else if (cmd.root_step || cmd.div_step) begin
            step_next = step_reg - 1'b1;
        end else begin
            step_next = step_reg;
        end

        priority if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire
